FILE: rtl/ciffv_pkg.sv
// ----------------------------------------------------------------------------
// CIFF stream validator package
// Shared types, phase and error codes, and constants of the CIFF parser.
// ----------------------------------------------------------------------------
package ciffv_pkg;

  typedef enum logic [9:0] {
    PH_MAGIC   = 10'b00_0000_0001,
    PH_HSIZE   = 10'b00_0000_0010,
    PH_CSIZE   = 10'b00_0000_0100,
    PH_WIDTH   = 10'b00_0000_1000,
    PH_HEIGHT  = 10'b00_0001_0000,
    PH_CAPTION = 10'b00_0010_0000,
    PH_TAGS    = 10'b00_0100_0000,
    PH_PIXEL   = 10'b00_1000_0000,
    PH_TRAIL   = 10'b01_0000_0000,
    PH_FAIL    = 10'b10_0000_0000
  } phase_t;

  localparam logic [3:0] PCODE_MAGIC   = 4'd0;
  localparam logic [3:0] PCODE_HSIZE   = 4'd1;
  localparam logic [3:0] PCODE_CSIZE   = 4'd2;
  localparam logic [3:0] PCODE_WIDTH   = 4'd3;
  localparam logic [3:0] PCODE_HEIGHT  = 4'd4;
  localparam logic [3:0] PCODE_CAPTION = 4'd5;
  localparam logic [3:0] PCODE_TAGS    = 4'd6;
  localparam logic [3:0] PCODE_PIXEL   = 4'd7;
  localparam logic [3:0] PCODE_TRAIL   = 4'd8;
  localparam logic [3:0] PCODE_FAIL    = 4'd9;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_MAGIC     = 3'd1;
  localparam logic [2:0] ERR_HDR_SIZE  = 3'd2;
  localparam logic [2:0] ERR_SIZE_REL  = 3'd3;
  localparam logic [2:0] ERR_CAPTION   = 3'd4;
  localparam logic [2:0] ERR_TAGS_END  = 3'd5;
  localparam logic [2:0] ERR_TRUNC     = 3'd6;

  localparam logic [7:0]  NEWLINE_BYTE   = 8'h0A;
  localparam logic [7:0]  NUL_BYTE       = 8'h00;
  localparam logic [2:0]  MAGIC_LAST_IDX = 3'd3;
  localparam logic [2:0]  FIELD_LAST_IDX = 3'd7;
  localparam logic [63:0] WIDTH_READ_POS  = 64'd28;
  localparam logic [63:0] HEIGHT_READ_POS = 64'd36;

  typedef struct packed {
    logic [63:0] height_value;
    logic [63:0] width_value;
    logic        pixel_valid;
    logic        header_done;
    logic        field_end;
    logic [2:0]  error_code;
    logic [3:0]  phase;
    logic [7:0]  byte_out;
  } result_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] val;
    case (idx)
      2'd0:    val = 8'h43;
      2'd1:    val = 8'h49;
      2'd2:    val = 8'h46;
      default: val = 8'h46;
    endcase
    return val;
  endfunction

  function automatic logic [3:0] phase_code(input phase_t ph);
    logic [3:0] code;
    case (ph)
      PH_MAGIC:   code = PCODE_MAGIC;
      PH_HSIZE:   code = PCODE_HSIZE;
      PH_CSIZE:   code = PCODE_CSIZE;
      PH_WIDTH:   code = PCODE_WIDTH;
      PH_HEIGHT:  code = PCODE_HEIGHT;
      PH_CAPTION: code = PCODE_CAPTION;
      PH_TAGS:    code = PCODE_TAGS;
      PH_PIXEL:   code = PCODE_PIXEL;
      PH_TRAIL:   code = PCODE_TRAIL;
      default:    code = PCODE_FAIL;
    endcase
    return code;
  endfunction

endpackage

FILE: rtl/ciff_stream_validator.sv
// ----------------------------------------------------------------------------
// CIFF stream validator
// Checks a CIFF file byte by byte and passes each byte on with its status.
// ----------------------------------------------------------------------------
// The in_ channel carries one file byte per transaction, with in_tlast on
// the final byte of the file. The out_ channel returns one transaction per
// input byte: the byte itself, its error code, the header-done flag and the
// image width and height in out_tdata, the parse phase and the pixel flag
// in out_tuser, and the end-of-field flag on out_tlast.
// A byte is captured in an input register and evaluated in one pass
// against the parse state on its way into the output register; one byte
// per cycle is sustained while the receiver takes every result. The
// evaluation path is bounded by the 64-by-8 multiply-add that accumulates
// width*3*height while the height field is read.
// Reset empties both registers and returns the parser to the magic phase
// with all sizes and the byte count cleared. When the receiver stalls, the
// output register holds its transaction; one more byte still enters the
// input register, and then in_tready stays low until the output moves.
// After a failure or after the pixel data the block stays in that phase
// until reset.
// ----------------------------------------------------------------------------
module ciff_stream_validator (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // data_byte[7:0]
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata,  // byte_out[7:0], error_code[10:8],
                                   // header_done[11], width_value[75:12],
                                   // height_value[139:76], zero[143:140]
  output logic [4:0]   out_tuser,  // phase[3:0], pixel_valid[4]
  output logic         out_tlast
);

  logic               in_vld_r, in_vld_nxt;
  logic [7:0]         in_data_r;
  logic               in_last_r;
  logic               out_vld_r, out_vld_nxt;
  ciffv_pkg::result_t out_res_r;
  ciffv_pkg::result_t result;
  logic               adv;
  logic               in_fire;

  assign adv       = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || adv;
  assign in_fire   = in_tvalid && in_tready;

  assign in_vld_nxt  = in_fire ? 1'b1 : (adv ? 1'b0 : in_vld_r);
  assign out_vld_nxt = adv ? 1'b1 : (out_tready ? 1'b0 : out_vld_r);

  ciffv_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .data_byte (in_data_r),
    .last_byte (in_last_r),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_data_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (adv) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'd0, out_res_r.height_value, out_res_r.width_value,
                       out_res_r.header_done, out_res_r.error_code,
                       out_res_r.byte_out};
  assign out_tuser  = {out_res_r.pixel_valid, out_res_r.phase};
  assign out_tlast  = out_res_r.field_end;

endmodule

FILE: rtl/ciffv_parser.sv
// ----------------------------------------------------------------------------
// CIFF parser core
// Holds the parse state and computes the result of one byte in one pass.
// ----------------------------------------------------------------------------
module ciffv_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  output ciffv_pkg::result_t result
);

  ciffv_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [63:0] hlen_r, hlen_nxt;
  logic [63:0] clen_r, clen_nxt;
  logic [63:0] width_r, width_nxt;
  logic [63:0] height_r, height_nxt;
  logic [63:0] w3_r, w3_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [63:0] bcnt_r, bcnt_nxt;

  logic [63:0] pos;
  logic [63:0] part;
  logic [63:0] part3;
  logic [5:0]  shamt;
  logic [9:0]  byte_x3;
  logic [2:0]  err;
  logic        fe;
  logic        hd;
  logic        pv;

  assign shamt   = {idx_r, 3'b000};
  assign part    = {56'd0, data_byte} << shamt;
  assign byte_x3 = {2'b00, data_byte} + {1'b0, data_byte, 1'b0};
  assign part3   = {54'd0, byte_x3} << shamt;
  assign pos     = (bcnt_r == '1) ? bcnt_r : bcnt_r + 64'd1;

  always_comb begin
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    hlen_nxt   = hlen_r;
    clen_nxt   = clen_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    w3_nxt     = w3_r;
    prod_nxt   = prod_r;
    bcnt_nxt   = bcnt_r;
    err        = ciffv_pkg::ERR_NONE;
    fe         = 1'b0;
    hd         = 1'b0;
    pv         = 1'b0;

    if (phase_r != ciffv_pkg::PH_TRAIL && phase_r != ciffv_pkg::PH_FAIL) begin
      bcnt_nxt = pos;
    end

    case (phase_r)
      ciffv_pkg::PH_MAGIC: begin
        if (data_byte != ciffv_pkg::magic_byte(idx_r[1:0])) begin
          err = ciffv_pkg::ERR_MAGIC;
        end else if (idx_r >= ciffv_pkg::MAGIC_LAST_IDX) begin
          fe        = 1'b1;
          idx_nxt   = 3'd0;
          phase_nxt = ciffv_pkg::PH_HSIZE;
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end
      ciffv_pkg::PH_HSIZE, ciffv_pkg::PH_CSIZE,
      ciffv_pkg::PH_WIDTH, ciffv_pkg::PH_HEIGHT: begin
        case (phase_r)
          ciffv_pkg::PH_HSIZE: hlen_nxt = hlen_r | part;
          ciffv_pkg::PH_CSIZE: clen_nxt = clen_r | part;
          ciffv_pkg::PH_WIDTH: begin
            width_nxt = width_r | part;
            w3_nxt    = w3_r + part3;
          end
          default: begin
            height_nxt = height_r | part;
            prod_nxt   = prod_r + ((w3_r * {56'd0, data_byte}) << shamt);
          end
        endcase
        if (idx_r != ciffv_pkg::FIELD_LAST_IDX) begin
          idx_nxt = idx_r + 3'd1;
        end else begin
          idx_nxt = 3'd0;
          fe      = 1'b1;
          if (phase_r == ciffv_pkg::PH_CSIZE && hlen_r > clen_nxt) begin
            err = ciffv_pkg::ERR_HDR_SIZE;
          end else if (phase_r == ciffv_pkg::PH_HEIGHT && prod_nxt != clen_r) begin
            err = ciffv_pkg::ERR_SIZE_REL;
          end else begin
            case (phase_r)
              ciffv_pkg::PH_HSIZE: phase_nxt = ciffv_pkg::PH_CSIZE;
              ciffv_pkg::PH_CSIZE: phase_nxt = ciffv_pkg::PH_WIDTH;
              ciffv_pkg::PH_WIDTH: phase_nxt = ciffv_pkg::PH_HEIGHT;
              default:             phase_nxt = ciffv_pkg::PH_CAPTION;
            endcase
          end
        end
      end
      ciffv_pkg::PH_CAPTION: begin
        if (data_byte == ciffv_pkg::NEWLINE_BYTE) begin
          if (pos >= hlen_r) begin
            err = ciffv_pkg::ERR_CAPTION;
          end else begin
            fe        = 1'b1;
            phase_nxt = ciffv_pkg::PH_TAGS;
          end
        end else if ({1'b0, hlen_r} < ({1'b0, pos} + 65'd2)) begin
          err = ciffv_pkg::ERR_CAPTION;
        end
      end
      ciffv_pkg::PH_TAGS: begin
        if (pos >= hlen_r) begin
          if (data_byte != ciffv_pkg::NUL_BYTE) begin
            err = ciffv_pkg::ERR_TAGS_END;
          end else begin
            fe        = 1'b1;
            hd        = 1'b1;
            phase_nxt = (clen_r == 64'd0) ? ciffv_pkg::PH_TRAIL : ciffv_pkg::PH_PIXEL;
          end
        end else if (data_byte == ciffv_pkg::NUL_BYTE) begin
          fe = 1'b1;
        end
      end
      ciffv_pkg::PH_PIXEL: begin
        pv = 1'b1;
        if (pos - hlen_r == clen_r) begin
          fe        = 1'b1;
          phase_nxt = ciffv_pkg::PH_TRAIL;
        end
      end
      default: begin
      end
    endcase

    if (err != ciffv_pkg::ERR_NONE) begin
      phase_nxt = ciffv_pkg::PH_FAIL;
      fe        = 1'b0;
      hd        = 1'b0;
    end else if (last_byte && phase_nxt != ciffv_pkg::PH_TRAIL &&
                 phase_nxt != ciffv_pkg::PH_FAIL) begin
      err       = ciffv_pkg::ERR_TRUNC;
      phase_nxt = ciffv_pkg::PH_FAIL;
      fe        = 1'b0;
    end
  end

  always_comb begin
    result.byte_out     = data_byte;
    result.phase        = (phase_nxt == ciffv_pkg::PH_FAIL) ? ciffv_pkg::PCODE_FAIL :
                          ciffv_pkg::phase_code(phase_r);
    result.error_code   = err;
    result.field_end    = fe;
    result.header_done  = hd;
    result.pixel_valid  = pv;
    result.width_value  = (bcnt_nxt >= ciffv_pkg::WIDTH_READ_POS)  ? width_nxt  : 64'd0;
    result.height_value = (bcnt_nxt >= ciffv_pkg::HEIGHT_READ_POS) ? height_nxt : 64'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= ciffv_pkg::PH_MAGIC;
      idx_r    <= 3'd0;
      hlen_r   <= 64'd0;
      clen_r   <= 64'd0;
      width_r  <= 64'd0;
      height_r <= 64'd0;
      w3_r     <= 64'd0;
      prod_r   <= 64'd0;
      bcnt_r   <= 64'd0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      hlen_r   <= hlen_nxt;
      clen_r   <= clen_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      w3_r     <= w3_nxt;
      prod_r   <= prod_nxt;
      bcnt_r   <= bcnt_nxt;
    end
  end

endmodule

FILE: rtl/ciffv_checker.sv
// ----------------------------------------------------------------------------
// CIFF stream validator checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module ciffv_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [143:0] out_tdata,
  input logic [4:0]   out_tuser,
  input logic         out_tlast
);

  logic [2:0] err_code;
  logic [3:0] phase;

  assign err_code = out_tdata[10:8];
  assign phase    = out_tuser[3:0];

  // A stalled result transaction must hold.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // An error is always reported in the failed phase.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && err_code != ciffv_pkg::ERR_NONE |-> phase == ciffv_pkg::PCODE_FAIL)
    else $error("error code outside failed phase");

  // A failing byte never ends a field.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && err_code != ciffv_pkg::ERR_NONE |-> !out_tlast)
    else $error("field end on failing byte");

  // Pixel bytes appear only in the pixel phase or on a truncated last byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[4] |->
      phase == ciffv_pkg::PCODE_PIXEL ||
      (phase == ciffv_pkg::PCODE_FAIL && err_code == ciffv_pkg::ERR_TRUNC))
    else $error("pixel flag outside pixel phase");

  // The header completes only on the closing zero byte of the tags.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[11] |->
      out_tdata[7:0] == ciffv_pkg::NUL_BYTE &&
      (phase == ciffv_pkg::PCODE_TAGS || phase == ciffv_pkg::PCODE_FAIL))
    else $error("header done on a byte other than the closing zero");

endmodule

bind ciff_stream_validator ciffv_checker u_ciffv_checker (.*);

FILE: tb/ciff_stream_validator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CIFF stream validator testbench
// Builds one CIFF file per run, either well formed or broken in one of the
// ways the parser must reject. The file is followed by trailing bytes. The
// bytes go through the in_ channel under changing idle patterns; each result
// is checked against fixed rows (first twelve bytes) or an in-bench parser model.
// ----------------------------------------------------------------------------
module ciff_stream_validator_test;

  localparam int TARGET_BYTES = 1850;
  localparam int QUIET_LIMIT  = 4000;
  localparam int HEADER_ROWS  = 20;
  localparam logic [7:0] CIFF_TAG [4] = '{8'h43, 8'h49, 8'h46, 8'h46};

  typedef enum int {
    FILE_OK, FILE_TRUNCATED, FILE_TAGS_OPEN, FILE_CAPTION_LONG,
    FILE_SIZE_MISMATCH, FILE_HEADER_BIG, FILE_BAD_MAGIC, FILE_EMPTY_IMAGE
  } file_kind_t;

  typedef struct {
    logic [7:0] b;
    logic       last;
    logic       typed;
    logic [3:0] ph;
    logic [2:0] err;
    logic       fe;
  } stim_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = 8'h00;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [143:0] out_tdata;
  logic [4:0]   out_tuser;
  logic         out_tlast;

  logic [3:0]  cur_phase;
  logic [2:0]  field_idx;
  logic [63:0] hdr_len;
  logic [63:0] cont_len;
  logic [63:0] img_w;
  logic [63:0] img_h;
  logic [63:0] size_acc;
  logic [63:0] file_pos;

  ciffv_pkg::result_t expected_status [$];
  stim_row_t          header_rows [HEADER_ROWS];
  stim_row_t          body_bytes [$];
  int                 fail_count = 0;
  int                 quiet_cycles = 0;
  int                 send_idle_pct = 0;
  int                 stall_pct = 0;

  ciff_stream_validator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  function automatic ciffv_pkg::result_t parse_step(input logic [7:0] b, input logic last);
    ciffv_pkg::result_t r;
    logic [3:0]  ph;
    logic [3:0]  out_ph;
    logic [2:0]  idx;
    logic [2:0]  err;
    logic        fe;
    logic        hd;
    logic        pv;
    logic [63:0] part;
    logic [63:0] pos;
    ph = cur_phase;
    idx = field_idx;
    out_ph = ph;
    err = ciffv_pkg::ERR_NONE;
    fe = 1'b0;
    hd = 1'b0;
    pv = 1'b0;
    part = 64'(b) << (8 * idx);
    pos = file_pos;
    if (ph <= ciffv_pkg::PCODE_PIXEL) begin
      if (pos != '1) pos = pos + 64'd1;
      file_pos = pos;
    end
    case (ph)
      ciffv_pkg::PCODE_MAGIC: begin
        if (b != CIFF_TAG[idx[1:0]]) begin
          err = ciffv_pkg::ERR_MAGIC;
        end else if (idx >= ciffv_pkg::MAGIC_LAST_IDX) begin
          fe = 1'b1;
          idx = 3'd0;
          ph = ciffv_pkg::PCODE_HSIZE;
        end else begin
          idx = idx + 3'd1;
        end
      end
      ciffv_pkg::PCODE_HSIZE, ciffv_pkg::PCODE_CSIZE,
      ciffv_pkg::PCODE_WIDTH, ciffv_pkg::PCODE_HEIGHT: begin
        if (ph == ciffv_pkg::PCODE_HSIZE) hdr_len = hdr_len | part;
        else if (ph == ciffv_pkg::PCODE_CSIZE) cont_len = cont_len | part;
        else if (ph == ciffv_pkg::PCODE_WIDTH) img_w = img_w | part;
        else begin
          img_h = img_h | part;
          size_acc = size_acc + (img_w * 64'd3) * part;
        end
        if (idx != ciffv_pkg::FIELD_LAST_IDX) begin
          idx = idx + 3'd1;
        end else begin
          idx = 3'd0;
          fe = 1'b1;
          if (ph == ciffv_pkg::PCODE_CSIZE && hdr_len > cont_len)
            err = ciffv_pkg::ERR_HDR_SIZE;
          else if (ph == ciffv_pkg::PCODE_HEIGHT && size_acc != cont_len)
            err = ciffv_pkg::ERR_SIZE_REL;
          else ph = ph + 4'd1;
        end
      end
      ciffv_pkg::PCODE_CAPTION: begin
        if (b == ciffv_pkg::NEWLINE_BYTE) begin
          if (pos >= hdr_len) begin
            err = ciffv_pkg::ERR_CAPTION;
          end else begin
            fe = 1'b1;
            ph = ciffv_pkg::PCODE_TAGS;
          end
        end else if (pos >= hdr_len || hdr_len - pos < 64'd2) begin
          err = ciffv_pkg::ERR_CAPTION;
        end
      end
      ciffv_pkg::PCODE_TAGS: begin
        if (pos >= hdr_len) begin
          if (b != ciffv_pkg::NUL_BYTE) begin
            err = ciffv_pkg::ERR_TAGS_END;
          end else begin
            fe = 1'b1;
            hd = 1'b1;
            ph = (cont_len == 64'd0) ? ciffv_pkg::PCODE_TRAIL : ciffv_pkg::PCODE_PIXEL;
          end
        end else if (b == ciffv_pkg::NUL_BYTE) begin
          fe = 1'b1;
        end
      end
      ciffv_pkg::PCODE_PIXEL: begin
        pv = 1'b1;
        if (pos - hdr_len == cont_len) begin
          fe = 1'b1;
          ph = ciffv_pkg::PCODE_TRAIL;
        end
      end
      default: ;
    endcase
    if (err != ciffv_pkg::ERR_NONE) begin
      ph = ciffv_pkg::PCODE_FAIL;
      fe = 1'b0;
      hd = 1'b0;
    end else if (last && ph != ciffv_pkg::PCODE_TRAIL && ph != ciffv_pkg::PCODE_FAIL) begin
      err = ciffv_pkg::ERR_TRUNC;
      ph = ciffv_pkg::PCODE_FAIL;
      fe = 1'b0;
    end
    if (ph == ciffv_pkg::PCODE_FAIL) out_ph = ciffv_pkg::PCODE_FAIL;
    cur_phase = ph;
    field_idx = idx;
    r.byte_out = b;
    r.phase = out_ph;
    r.error_code = err;
    r.field_end = fe;
    r.header_done = hd;
    r.pixel_valid = pv;
    r.width_value = (file_pos >= ciffv_pkg::WIDTH_READ_POS) ? img_w : 64'd0;
    r.height_value = (file_pos >= ciffv_pkg::HEIGHT_READ_POS) ? img_h : 64'd0;
    return r;
  endfunction

  function automatic stim_row_t plain_row(input logic [7:0] b);
    stim_row_t row;
    row = '{b, 1'b0, 1'b0, ciffv_pkg::PCODE_MAGIC, ciffv_pkg::ERR_NONE, 1'b0};
    return row;
  endfunction

  task automatic set_pace(input int n, input int offset);
    case (((n + offset) / 50) % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 73; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 73; end
      default: begin send_idle_pct = 36; stall_pct = 36; end
    endcase
  endtask

  // Starts and ends at a falling edge.
  task automatic send_byte(input stim_row_t row);
    ciffv_pkg::result_t exp;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= row.b;
    in_tlast <= row.last;
    do @(posedge clk); while (!in_tready);
    exp = parse_step(row.b, row.last);
    if (row.typed) begin
      exp = '0;
      exp.byte_out = row.b;
      exp.phase = row.ph;
      exp.error_code = row.err;
      exp.field_end = row.fe;
    end
    expected_status.insert(expected_status.size(), exp);
    @(negedge clk);
  endtask

  always @(negedge clk) out_tready <= ($urandom_range(0, 99) >= stall_pct);

  always @(posedge clk) begin
    ciffv_pkg::result_t act;
    ciffv_pkg::result_t exp;
    if (rst_n && out_tvalid && out_tready) begin
      act.byte_out = out_tdata[7:0];
      act.error_code = out_tdata[10:8];
      act.header_done = out_tdata[11];
      act.width_value = out_tdata[75:12];
      act.height_value = out_tdata[139:76];
      act.phase = out_tuser[3:0];
      act.pixel_valid = out_tuser[4];
      act.field_end = out_tlast;
      if (expected_status.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: result with nothing pending, byte %h phase %0d",
                   $realtime, act.byte_out, act.phase);
      end else begin
        exp = expected_status.pop_front();
        if (act !== exp) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: expected byte %h ph %0d err %0d fe %b hd %b pv %b w %h h %h",
                     $realtime, exp.byte_out, exp.phase, exp.error_code, exp.field_end,
                     exp.header_done, exp.pixel_valid, exp.width_value, exp.height_value);
            $display("%0t: actual   byte %h ph %0d err %0d fe %b hd %b pv %b w %h h %h",
                     $realtime, act.byte_out, act.phase, act.error_code, act.field_end,
                     act.header_done, act.pixel_valid, act.width_value, act.height_value);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : main
    file_kind_t  kind;
    int          pick;
    int          cap_len;
    int          tag_len;
    int          n;
    int          offset;
    int          k;
    int          file_len;
    logic [63:0] hsize;
    logic [63:0] csize;
    logic [63:0] wval;
    logic [63:0] hval;
    logic [7:0]  b;
    stim_row_t   row;

    cur_phase = ciffv_pkg::PCODE_MAGIC;
    field_idx = 3'd0;
    hdr_len = '0;
    cont_len = '0;
    img_w = '0;
    img_h = '0;
    size_acc = '0;
    file_pos = '0;

    pick = $urandom_range(0, 15);
    kind = (pick < 8) ? FILE_OK : (pick == 15) ? FILE_TRUNCATED : file_kind_t'(pick - 7);
    cap_len = $urandom_range(0, 24);
    tag_len = $urandom_range(1, 12);
    hsize = 64'(37 + cap_len + tag_len);
    if ($urandom_range(0, 3) == 0) begin
      // Width times three wraps around to two, so the content is twice the height.
      wval = 64'h5555_5555_5555_5556;
      hval = 64'($urandom_range(40, 700));
    end else begin
      do begin
        wval = 64'($urandom_range(1, 24));
        hval = 64'($urandom_range(1, 24));
      end while (wval * hval * 64'd3 < hsize);
    end
    csize = wval * hval * 64'd3;
    case (kind)
      FILE_SIZE_MISMATCH: csize = csize + 64'd1;
      FILE_HEADER_BIG:    csize = hsize - 64'd1;
      FILE_CAPTION_LONG:  cap_len = cap_len + tag_len + $urandom_range(0, 2);
      FILE_EMPTY_IMAGE: begin
        wval = 64'd0;
        csize = 64'd0;
        hsize = 64'd0;
      end
      default: ;
    endcase

    for (int i = 0; i < 4; i++)
      header_rows[i] = '{CIFF_TAG[i], 1'b0, 1'b1, ciffv_pkg::PCODE_MAGIC,
                         ciffv_pkg::ERR_NONE, i == 3};
    for (int i = 0; i < 8; i++)
      header_rows[4 + i] = '{hsize[8*i +: 8], 1'b0, 1'b1, ciffv_pkg::PCODE_HSIZE,
                             ciffv_pkg::ERR_NONE, i == 7};
    for (int i = 0; i < 8; i++)
      header_rows[12 + i] = plain_row(csize[8*i +: 8]);
    if (kind == FILE_BAD_MAGIC) begin
      k = $urandom_range(0, 3);
      header_rows[k].b = header_rows[k].b ^ 8'($urandom_range(1, 255));
      header_rows[k].err = ciffv_pkg::ERR_MAGIC;
      for (int i = k; i < 12; i++) begin
        header_rows[i].ph = ciffv_pkg::PCODE_FAIL;
        header_rows[i].fe = 1'b0;
      end
    end

    for (int i = 0; i < 8; i++)
      body_bytes.insert(body_bytes.size(), plain_row(wval[8*i +: 8]));
    for (int i = 0; i < 8; i++)
      body_bytes.insert(body_bytes.size(), plain_row(hval[8*i +: 8]));
    for (int i = 0; i < cap_len; i++) begin
      do b = 8'($urandom); while (b == ciffv_pkg::NEWLINE_BYTE);
      body_bytes.insert(body_bytes.size(), plain_row(b));
    end
    body_bytes.insert(body_bytes.size(), plain_row(ciffv_pkg::NEWLINE_BYTE));
    for (int i = 0; i < tag_len - 1; i++)
      body_bytes.insert(body_bytes.size(),
                        plain_row(($urandom_range(0, 3) == 0) ? ciffv_pkg::NUL_BYTE :
                                                                8'($urandom)));
    body_bytes.insert(body_bytes.size(),
                      plain_row((kind == FILE_TAGS_OPEN) ? 8'($urandom_range(1, 255)) :
                                                           ciffv_pkg::NUL_BYTE));
    for (longint i = 0; i < longint'(csize) && i < 2000; i++)
      body_bytes.insert(body_bytes.size(), plain_row(8'($urandom)));
    file_len = body_bytes.size();
    if (kind == FILE_OK) body_bytes[file_len - 1].last = 1'($urandom_range(0, 1));
    if (kind == FILE_TRUNCATED) body_bytes[$urandom_range(0, file_len - 2)].last = 1'b1;
    n = TARGET_BYTES - HEADER_ROWS - file_len;
    if (n < 8) n = 8;
    for (int i = 0; i < n; i++) begin
      row = plain_row(8'($urandom));
      row.last = ($urandom_range(0, 7) == 0);
      body_bytes.insert(body_bytes.size(), row);
    end

    offset = $urandom_range(0, 199);
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    n = 0;
    foreach (header_rows[i]) begin
      set_pace(n, offset);
      send_byte(header_rows[i]);
      n++;
    end
    foreach (body_bytes[i]) begin
      set_pace(n, offset);
      send_byte(body_bytes[i]);
      n++;
    end
    in_tvalid <= 1'b0;
    in_tlast <= 1'b0;

    wait (expected_status.size() == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
